@@ hdl/jhmi_pkg.sv @@
`default_nettype none
package jhmi_pkg;

    localparam int MAX_BINS    = 16;
    localparam int BIN_W       = 4;
    localparam int CELLS       = MAX_BINS * MAX_BINS;
    localparam int CELL_AW     = 8;
    localparam int CNT_W       = 17;
    localparam int MAX_SAMPLES = 65536;
    localparam int CFG_W       = 5;
    localparam int LOG_W       = 37;
    localparam int SUM_W       = 58;
    localparam int MI_W        = 26;
    localparam int IDX_W       = 9;

    localparam logic [IDX_W-1:0] IDX_LAST = 9'd288;
    localparam logic [3:0]       GRP_ROW  = 4'd0;
    localparam logic [3:0]       GRP_COL  = 4'd1;
    localparam logic [63:0]      LN2_Q64  = 64'hB17217F7D1CF79AB;
    localparam logic [MI_W-1:0]  MI_MAX   = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_WR,
        S_W_INIT,
        S_W_FETCH,
        S_W_LOAD,
        S_L_MUL,
        S_L_CHK,
        S_P_LO,
        S_P_HI,
        S_P_ADD,
        S_W_NEXT,
        S_FIN,
        S_DIV,
        S_LN_ISS,
        S_LN_ACC,
        S_ROUND
    } t_state;

    typedef struct packed {
        logic        busy;
        logic        done;
    } t_div_stat;

    // position of the leading one
    function automatic logic [4:0] msb_pos(input logic [CNT_W-1:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage
`default_nettype wire

@@ hdl/jhmi_ram.sv @@
`default_nettype none
module jhmi_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/jhmi_mul.sv @@
`default_nettype none
module jhmi_mul
    import jhmi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_en,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [63:0] o_p
);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= 64'(i_a) * 64'(i_b);
        end
    end

endmodule
`default_nettype wire

@@ hdl/jhmi_div.sv @@
`default_nettype none
module jhmi_div
    import jhmi_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [SUM_W-1:0] i_dividend,
    input  wire  [CNT_W-1:0] i_divisor,
    output t_div_stat        o_stat,
    output logic [SUM_W-1:0] o_quot
);

    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_dvs;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W:0]   trial;
    logic             qbit;

    // restoring, one quotient bit a cycle
    always_comb begin
        trial = {r_rem, o_quot[SUM_W-1]};
        qbit  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                o_quot <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= qbit ? CNT_W'(trial - {1'b0, r_dvs}) : trial[CNT_W-1:0];
                o_quot <= {o_quot[SUM_W-2:0], qbit};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

@@ hdl/joint_histogram_mutual_information.sv @@
`default_nettype none
// channel   direction  payload
// i_s_*     in         tdata[3:0] bin_x, tdata[7:4] bin_y, tlast last_sample
// o_m_*     out        tdata[25:0] mutual_info, [42:26] samples_counted; tuser input_error
// i_cfg_*   in         bins_in_use, written when i_cfg_wr_en is high
// an accepted sample is read from the table, then written back; a dropped one is not written
// a last sample then starts a walk over 256 cells, 32 totals and the sample total;
// each nonzero entry uses the shared 32x32 multiplier (log2 by 32 squarings plus two partial
// products), a zero one skips it; then the divider runs and partial products scale by ln 2
// the table is cleared at once through per-cell valid bits, so reset needs no pass
// a pending result does not hold off input; a second result waits for the first
module joint_histogram_mutual_information
    import jhmi_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    input  wire  [7:0]       i_s_tdata,   // bin_x, bin_y
    input  wire              i_s_tlast,   // last_sample
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    output logic [47:0]      o_m_tdata,   // mutual_info, samples_counted, zero pad
    output logic             o_m_tuser,   // input_error
    input  wire              i_cfg_wr_en,
    input  wire  [CFG_W-1:0] i_cfg_wr_data
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_bins;
    logic [CNT_W-1:0]   r_rows [MAX_BINS];
    logic [CNT_W-1:0]   r_cols [MAX_BINS];
    logic [CNT_W-1:0]   r_n;
    logic               r_err;
    logic [CELLS-1:0]   r_vld;
    logic [CELL_AW-1:0] r_addr;
    logic               r_last;

    logic [IDX_W-1:0]   r_idx;
    logic               r_neg;
    logic [CNT_W-1:0]   r_x;
    logic [31:0]        r_m;
    logic [LOG_W-1:0]   r_lg;
    logic [5:0]         r_step;
    logic [48:0]        r_t;
    logic signed [SUM_W-1:0] r_s;
    logic [127:0]       r_acc;
    logic [1:0]         r_k;
    logic [MI_W-1:0]    r_res;

    logic               r_ov;
    logic [MI_W-1:0]    r_omi;
    logic [CNT_W-1:0]   r_ocnt;
    logic               r_oerr;

    logic [BIN_W-1:0]   bx, by;
    logic [CFG_W-1:0]   eff;
    logic               s_fire, ok, load_go;

    logic               ram_we, ram_re;
    logic [CELL_AW-1:0] ram_waddr, ram_raddr;
    logic [CNT_W-1:0]   ram_wdata, ram_rdata;

    logic               mul_en;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;

    logic               div_start;
    t_div_stat          div_stat;
    logic [SUM_W-1:0]   div_q;

    logic [CNT_W-1:0]   wval;
    logic [4:0]         wmsb;
    logic [54:0]        term;
    logic [56:0]        vr;

    jhmi_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    jhmi_mul u_mul (
        .i_clk(i_clk),
        .i_en (mul_en),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_p  (mul_p)
    );

    jhmi_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(SUM_W'(r_s) + SUM_W'(r_n >> 1)),
        .i_divisor (r_n),
        .o_stat    (div_stat),
        .o_quot    (div_q)
    );

    always_comb begin
        bx      = i_s_tdata[BIN_W-1:0];
        by      = i_s_tdata[2*BIN_W-1:BIN_W];
        eff     = (r_bins > CFG_W'(MAX_BINS)) ? CFG_W'(MAX_BINS) : r_bins;
        ok      = ({1'b0, bx} < eff) && ({1'b0, by} < eff)
                  && (r_n < CNT_W'(MAX_SAMPLES));
        s_fire  = i_s_tvalid && o_s_tready;
        load_go = !r_ov || i_m_tready;

        // value whose x*log2(x) is summed at this walk position
        if (!r_idx[IDX_W-1]) begin
            wval = r_vld[r_idx[CELL_AW-1:0]] ? ram_rdata : '0;
        end else if (r_idx[7:4] == GRP_ROW) begin
            wval = r_rows[r_idx[3:0]];
        end else if (r_idx[7:4] == GRP_COL) begin
            wval = r_cols[r_idx[3:0]];
        end else begin
            wval = r_n;
        end
        wmsb = msb_pos(wval);
        term = 55'(r_t) + {mul_p[22:0], 32'b0};
        vr   = 57'((r_acc[127:64] + 64'd128) >> 8);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if (ok)             n_state = S_ACC_WR;
                    else if (i_s_tlast) n_state = S_W_INIT;
                end
            end
            S_ACC_WR:  n_state = r_last ? S_W_INIT : S_IDLE;
            S_W_INIT:  n_state = S_W_FETCH;
            S_W_FETCH: n_state = S_W_LOAD;
            S_W_LOAD:  n_state = (wval == '0) ? S_W_NEXT : S_L_MUL;
            S_L_MUL:   n_state = S_L_CHK;
            S_L_CHK:   n_state = (r_step == 6'd32) ? S_P_LO : S_L_MUL;
            S_P_LO:    n_state = S_P_HI;
            S_P_HI:    n_state = S_P_ADD;
            S_P_ADD:   n_state = S_W_NEXT;
            S_W_NEXT:  n_state = (r_idx == IDX_LAST) ? S_FIN : S_W_FETCH;
            S_FIN:     n_state = (r_n == '0 || r_s <= 0) ? S_ROUND : S_DIV;
            S_DIV:     n_state = div_stat.done ? S_LN_ISS : S_DIV;
            S_LN_ISS:  n_state = S_LN_ACC;
            S_LN_ACC:  n_state = (r_k == 2'd3) ? S_ROUND : S_LN_ISS;
            S_ROUND:   n_state = load_go ? S_IDLE : S_ROUND;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = (r_vld[r_addr] ? ram_rdata : '0) + CNT_W'(1);
        ram_raddr  = r_idx[CELL_AW-1:0];
        mul_en     = 1'b0;
        mul_a      = r_m;
        mul_b      = r_m;
        div_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                ram_re     = s_fire;
                ram_raddr  = {bx, by};
            end
            S_ACC_WR:  ram_we = 1'b1;
            S_W_FETCH: ram_re = !r_idx[IDX_W-1];
            S_L_MUL:   mul_en = 1'b1;
            S_P_LO: begin
                mul_en = 1'b1;
                mul_a  = 32'(r_x);
                mul_b  = r_lg[31:0];
            end
            S_P_HI: begin
                mul_en = 1'b1;
                mul_a  = 32'(r_x);
                mul_b  = 32'(r_lg[LOG_W-1:32]);
            end
            S_FIN:     div_start = (r_n != '0) && (r_s > 0);
            S_LN_ISS: begin
                mul_en = 1'b1;
                mul_a  = r_k[1] ? 32'(div_q[SUM_W-1:32]) : div_q[31:0];
                mul_b  = r_k[0] ? LN2_Q64[63:32] : LN2_Q64[31:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bins  <= CFG_W'(MAX_BINS);
            r_n     <= '0;
            r_err   <= 1'b0;
            r_vld   <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < MAX_BINS; i++) begin
                r_rows[i] <= '0;
                r_cols[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_bins <= i_cfg_wr_data;
            end
            if (o_m_tvalid && i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_addr <= {bx, by};
                        r_last <= i_s_tlast;
                        if (ok) begin
                            r_rows[bx] <= r_rows[bx] + CNT_W'(1);
                            r_cols[by] <= r_cols[by] + CNT_W'(1);
                            r_n        <= r_n + CNT_W'(1);
                        end else begin
                            r_err <= 1'b1;
                        end
                    end
                end
                S_ACC_WR: r_vld[r_addr] <= 1'b1;
                S_W_INIT: begin
                    r_idx <= '0;
                    r_s   <= '0;
                end
                S_W_LOAD: begin
                    r_x    <= wval;
                    r_neg  <= r_idx[IDX_W-1] && (r_idx != IDX_LAST);
                    r_m    <= 32'(wval) << (5'd31 - wmsb);
                    r_lg   <= {wmsb, 32'b0};
                    r_step <= 6'd1;
                end
                S_L_CHK: begin
                    if (mul_p[63]) begin
                        r_m  <= mul_p[63:32];
                        r_lg <= r_lg | (LOG_W'(1) << (6'd32 - r_step));
                    end else begin
                        r_m  <= mul_p[62:31];
                    end
                    r_step <= r_step + 6'd1;
                end
                S_P_HI:   r_t <= mul_p[48:0];
                S_P_ADD:  r_s <= r_neg ? r_s - SUM_W'(term) : r_s + SUM_W'(term);
                S_W_NEXT: r_idx <= r_idx + IDX_W'(1);
                S_FIN: begin
                    r_res <= '0;
                    r_acc <= '0;
                    r_k   <= '0;
                end
                S_LN_ACC: begin
                    r_acc <= r_acc + ((r_k == 2'd0) ? 128'(mul_p)
                                    : (r_k == 2'd3) ? {mul_p, 64'b0}
                                    : {32'b0, mul_p, 32'b0});
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_res <= '1;
                    end
                end
                S_ROUND: begin
                    if (load_go) begin
                        r_ov   <= 1'b1;
                        r_omi  <= (r_res == '0) ? '0
                                  : (vr > 57'(MI_MAX)) ? MI_MAX : vr[MI_W-1:0];
                        r_ocnt <= r_n;
                        r_oerr <= r_err;
                        r_n    <= '0;
                        r_err  <= 1'b0;
                        r_vld  <= '0;
                        for (int i = 0; i < MAX_BINS; i++) begin
                            r_rows[i] <= '0;
                            r_cols[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'b0, r_ocnt, r_omi};
    assign o_m_tuser  = r_oerr;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_SAMPLES))
        else $error("sample total beyond limit");

    a_acc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && ok) |=> (r_state == S_ACC_WR))
        else $error("accepted sample not written back");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && load_go) |=> (r_n == '0 && !r_err && r_vld == '0 && r_ov))
        else $error("store not cleared on result");

    a_log_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_L_MUL) |=> (r_state == S_L_CHK))
        else $error("log step lost its product");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_stat.busy || r_state == S_ACC_WR) |-> !o_s_tready)
        else $error("input taken while busy");

endmodule
`default_nettype wire

@@ tb/sv/joint_histogram_mutual_information_tb.sv @@
`timescale 1ns / 100ps
module joint_histogram_mutual_information_tb;
    import jhmi_pkg::*;

    typedef struct {
        logic [BIN_W-1:0] bin_x;
        logic [BIN_W-1:0] bin_y;
        logic             last;
        logic             no_gap;
    } t_sample;

    typedef struct {
        logic [MI_W-1:0]  mi;
        logic [CNT_W-1:0] count;
        logic             err;
    } t_mi_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_valid = 1'b0;
    logic [7:0]        s_data = '0;
    logic              s_last = 1'b0;
    logic              m_ready = 1'b0;
    logic              cfg_en = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;
    wire               s_ready;
    wire               m_valid;
    wire  [47:0]       m_data;
    wire               m_user;

    joint_histogram_mutual_information u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_valid),
        .o_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tlast     (s_last),
        .o_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .o_m_tdata     (m_data),
        .o_m_tuser     (m_user),
        .i_cfg_wr_en   (cfg_en),
        .i_cfg_wr_data (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    t_sample       pending_samples[$];
    t_mi_result    expected_mi[$];
    int            fail_count = 0;
    bit            burst_mode = 1'b0;

    // histogram copy kept by the testbench
    logic [CFG_W-1:0] bins_cfg = 5'd16;
    int unsigned      cell_cnt[CELLS];
    int unsigned      row_cnt[MAX_BINS];
    int unsigned      col_cnt[MAX_BINS];
    int unsigned      total_cnt = 0;
    bit               drop_seen = 1'b0;

    function automatic longint unsigned log2_fix32(input longint unsigned x);
        int unsigned     e;
        longint unsigned m;
        longint unsigned r;
        e = 0;
        if (x == 0) begin
            return 0;
        end
        while ((x >> e) > 1) begin
            e++;
        end
        m = x << (31 - e);
        r = longint'(e) << 32;
        for (int i = 1; i <= 32; i++) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                r = r | (64'd1 << (32 - i));
            end
        end
        return r;
    endfunction

    function automatic logic [MI_W-1:0] mutual_info_fix();
        longint          s;
        longint          d;
        longint          log_n;
        longint unsigned n;
        longint unsigned q;
        logic [127:0]    prod;
        longint unsigned v;
        int unsigned     c;
        s = 0;
        n = total_cnt;
        if (n == 0) begin
            return '0;
        end
        log_n = longint'(log2_fix32(n));
        for (int i = 0; i < MAX_BINS; i++) begin
            for (int j = 0; j < MAX_BINS; j++) begin
                c = cell_cnt[i*MAX_BINS+j];
                if (c == 0 || row_cnt[i] == 0 || col_cnt[j] == 0) begin
                    continue;
                end
                d = longint'(log2_fix32(c)) + log_n - longint'(log2_fix32(row_cnt[i]))
                    - longint'(log2_fix32(col_cnt[j]));
                s += longint'(c) * d;
            end
        end
        if (s <= 0) begin
            return '0;
        end
        q = (longint'(s) + n / 2) / n;
        prod = {64'd0, q} * {64'd0, LN2_Q64};
        v = prod[127:64];
        v = (v + 128) >> 8;
        if (v > longint'(MI_MAX)) begin
            v = longint'(MI_MAX);
        end
        return v[MI_W-1:0];
    endfunction

    task automatic count_sample(input t_sample smp);
        int unsigned eff;
        t_mi_result  res;
        eff = (bins_cfg > MAX_BINS) ? MAX_BINS : bins_cfg;
        if (smp.bin_x >= eff || smp.bin_y >= eff || total_cnt >= MAX_SAMPLES) begin
            drop_seen = 1'b1;
        end else begin
            cell_cnt[smp.bin_x*MAX_BINS+smp.bin_y]++;
            row_cnt[smp.bin_x]++;
            col_cnt[smp.bin_y]++;
            total_cnt++;
        end
        if (smp.last) begin
            res.mi    = mutual_info_fix();
            res.count = total_cnt[CNT_W-1:0];
            res.err   = drop_seen;
            expected_mi = {expected_mi, res};
            for (int i = 0; i < CELLS; i++) cell_cnt[i] = 0;
            for (int i = 0; i < MAX_BINS; i++) begin
                row_cnt[i] = 0;
                col_cnt[i] = 0;
            end
            total_cnt = 0;
            drop_seen = 1'b0;
        end
    endtask

    // sample driver
    int      send_wait = 0;
    t_sample cur;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                count_sample(cur);
            end
            if (s_valid && !s_ready) begin
                // hold the transfer
            end else if (send_wait != 0) begin
                s_valid <= 1'b0;
                send_wait <= send_wait - 1;
            end else if (pending_samples.size() != 0) begin
                cur = pending_samples.pop_front();
                s_data <= {cur.bin_y, cur.bin_x};
                s_last <= cur.last;
                s_valid <= 1'b1;
                send_wait <= (cur.no_gap || burst_mode) ? 0 : $urandom_range(0, 17);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    int         recv_stall = 0;
    t_mi_result want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_mi.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    want = expected_mi.pop_front();
                    if (m_data[MI_W-1:0] !== want.mi) begin
                        $error("mutual_info expected %0d got %0d", want.mi, m_data[MI_W-1:0]);
                        fail_count++;
                    end
                    if (m_data[MI_W+CNT_W-1:MI_W] !== want.count) begin
                        $error("samples_counted expected %0d got %0d", want.count,
                               m_data[MI_W+CNT_W-1:MI_W]);
                        fail_count++;
                    end
                    if (m_user !== want.err) begin
                        $error("input_error expected %0d got %0d", want.err, m_user);
                        fail_count++;
                    end
                end
                recv_stall = burst_mode ? 0 : $urandom_range(0, 17);
            end
            if (recv_stall != 0) begin
                m_ready <= 1'b0;
                recv_stall = recv_stall - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_sample(input int x, input int y, input bit last, input bit no_gap = 0);
        t_sample smp;
        smp.bin_x  = BIN_W'(x);
        smp.bin_y  = BIN_W'(y);
        smp.last   = last;
        smp.no_gap = no_gap;
        pending_samples = {pending_samples, smp};
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_mi.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_bins(input int value);
        @(posedge i_clk);
        cfg_en <= 1'b1;
        cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        cfg_en <= 1'b0;
        bins_cfg = CFG_W'(value);
    endtask

    task automatic random_sets(input int n_items);
        int eff;
        int left;
        int len;
        int x;
        int y;
        eff = (bins_cfg > MAX_BINS) ? MAX_BINS : bins_cfg;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, 30);
            for (int k = 0; k < len; k++) begin
                if (eff == 0 || $urandom_range(0, 11) == 0) begin
                    x = $urandom_range(0, 15);
                    y = $urandom_range(0, 15);
                end else begin
                    x = $urandom_range(0, eff - 1);
                    // half the pairs dependent so the estimate is well away from zero
                    if ($urandom_range(0, 1) == 0) begin
                        y = (x + $urandom_range(0, 1)) % eff;
                    end else begin
                        y = $urandom_range(0, eff - 1);
                    end
                end
                push_sample(x, y, k == len - 1);
            end
            left -= len;
        end
    endtask

    initial begin
        int cfgs[8];
        for (int i = 0; i < CELLS; i++) cell_cnt[i] = 0;
        for (int i = 0; i < MAX_BINS; i++) begin
            row_cnt[i] = 0;
            col_cnt[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset width of 16 bins, corner indices
        push_sample(0, 0, 1);
        push_sample(15, 15, 0);
        push_sample(0, 15, 0);
        push_sample(15, 0, 0);
        push_sample(10, 5, 1);
        push_sample(3, 3, 0);
        push_sample(7, 7, 1);
        wait_idle();
        // one bin only: everything beyond index 0 is dropped
        write_bins(1);
        push_sample(0, 0, 0);
        push_sample(1, 0, 0);
        push_sample(0, 1, 1);
        wait_idle();
        // zero bins: all rejected, empty set
        write_bins(0);
        push_sample(0, 0, 0);
        push_sample(15, 15, 1);
        wait_idle();
        // width above the maximum acts as the maximum
        write_bins(31);
        push_sample(15, 14, 0);
        push_sample(14, 15, 0);
        push_sample(12, 3, 1);
        wait_idle();

        cfgs = '{16, 5, 1, 31, 2, 0, 12, 16};
        for (int p = 0; p < 8; p++) begin
            burst_mode = ($urandom_range(0, 3) == 0);
            write_bins(cfgs[p]);
            random_sets(cfgs[p] == 0 ? 60 : 280);
            wait_idle();
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
